// ===== src/pca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_pkg: shared types and constants for the pair correlation accumulator
// Field widths, command and result structs, fixed-point constants.
// ----------------------------------------------------------------------------
package pca_pkg;

   // sizing
   localparam int NUM_K      = 4;
   localparam int TIME_BINS  = 16;
   localparam int KCW        = (NUM_K > 1) ? $clog2(NUM_K) : 1;
   localparam int LW         = (TIME_BINS > 1) ? $clog2(TIME_BINS) : 1;
   localparam int ACC_DEPTH  = NUM_K * TIME_BINS;
   localparam int AW         = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

   // field widths
   localparam int POS_W  = 24;
   localparam int ID_W   = 20;
   localparam int LAG_W  = 4;
   localparam int TOT_W  = 20;
   localparam int WAVE_W = 16;
   localparam int DISP_W = 26;
   localparam int SUM_W  = 27;
   localparam int ACC_W  = 48;
   localparam int CNT_W  = 32;
   localparam int COS_W  = 16;
   localparam int CORR_W = 32;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 24;

   // queue
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   // opcodes
   localparam logic [1:0] OP_PAIR   = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_BOX_X  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_BOX_Y  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_BOX_Z  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_WAVE_0 = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_MAX_DT = 3'd7;

   // phase scale (about 2^38 / (6*pi)) split into two 17-bit halves
   localparam logic [33:0] PHASE_MUL = 34'd14582725879;
   localparam logic [16:0] PHASE_HI  = PHASE_MUL[33:17];
   localparam logic [16:0] PHASE_LO  = PHASE_MUL[16:0];

   // sine polynomial
   localparam logic [14:0] POLY_A = 15'd25736;
   localparam logic [14:0] POLY_B = 15'd10512;
   localparam logic [14:0] POLY_C = 15'd1160;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [POS_W-1:0]  pos_a_x;
      logic [POS_W-1:0]  pos_a_y;
      logic [POS_W-1:0]  pos_a_z;
      logic [POS_W-1:0]  pos_b_x;
      logic [POS_W-1:0]  pos_b_y;
      logic [POS_W-1:0]  pos_b_z;
      logic [ID_W-1:0]   particle_id_a;
      logic [ID_W-1:0]   particle_id_b;
      logic [LAG_W-1:0]  time_lag;
      logic [TOT_W-1:0]  particle_total;
   } req_type;

   typedef struct packed {
      logic [1:0]               wave_index;
      logic [3:0]               lag_index;
      logic signed [CORR_W-1:0] correlation;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]                box_x;
      logic [POS_W-1:0]                box_y;
      logic [POS_W-1:0]                box_z;
      logic [NUM_K-1:0][WAVE_W-1:0]    wave_number;
      logic [LAG_W-1:0]                max_delta_t;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_PAIR   = 3'b001,
      CMD_SAMPLE = 3'b010,
      CMD_READ   = 3'b100
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [LAG_W-1:0]         lag;
      logic signed [DISP_W-1:0] dx;
      logic signed [DISP_W-1:0] dy;
      logic signed [DISP_W-1:0] dz;
      logic [TOT_W-1:0]         total;
   } cmd_type;

   typedef struct packed {
      logic                    valid;
      logic [WAVE_W-1:0]       k;
      logic signed [SUM_W-1:0] s;
      logic [AW-1:0]           addr;
   } cos_req_type;

   typedef struct packed {
      logic          valid;
      logic [AW-1:0] addr;
   } cos_tag_type;

   typedef struct packed {
      logic                    valid;
      logic [AW-1:0]           addr;
      logic signed [COS_W-1:0] value;
   } cos_rsp_type;

endpackage

// ===== src/pair_correlation_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_correlation_accumulator: intermediate scattering function pair sum
// Folds pair displacements into the box, adds cosine terms per (k, lag) and
// reads out normalized correlations.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | req_data (req_type)
//   rsp     | out       | rsp_valid / rsp_ready   | rsp_data (rsp_type)
//   csr     | in        | csr_wen                 | csr_index, csr_wdata
//
// The front takes one item per cycle into a four-entry command queue, unless the queue is full.
// A pair occupies the back for one cosine pipeline issue per wave
// number; a sample item only updates the sample count of its lag.
// A read out waits for the seven-stage cosine pipeline to drain, then walks each result through
// address, load, prepare, the bit-serial divider and output.
// Reset clears all sums and counts at once; no clearing pass.
// Either side may stall; the result register holds until taken.
// ----------------------------------------------------------------------------
module pair_correlation_accumulator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pca_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pca_pkg::rsp_type               rsp_data,
   input  logic                           csr_wen,
   input  logic [pca_pkg::CSR_IW-1:0]     csr_index,
   input  logic [pca_pkg::CSR_DW-1:0]     csr_wdata
);

   pca_pkg::cfg_type     cfg_ff, cfg_in;
   logic                 q_push, q_full, q_pop, q_empty;
   pca_pkg::cmd_type     q_cmd, q_head;
   pca_pkg::cos_req_type cos_req;
   pca_pkg::cos_tag_type cos_pre;
   pca_pkg::cos_rsp_type cos_rsp;
   logic                 cos_busy;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            pca_pkg::CSR_BOX_X:  cfg_in.box_x = csr_wdata;
            pca_pkg::CSR_BOX_Y:  cfg_in.box_y = csr_wdata;
            pca_pkg::CSR_BOX_Z:  cfg_in.box_z = csr_wdata;
            pca_pkg::CSR_MAX_DT: cfg_in.max_delta_t = csr_wdata[pca_pkg::LAG_W-1:0];
            default: begin
               for (int i = 0; i < pca_pkg::NUM_K; i++) begin
                  if (csr_index == pca_pkg::CSR_IW'(int'(pca_pkg::CSR_WAVE_0) + i)) begin
                     cfg_in.wave_number[i] = csr_wdata[pca_pkg::WAVE_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_x       <= '1;
         cfg_ff.box_y       <= '1;
         cfg_ff.box_z       <= '1;
         cfg_ff.wave_number <= '0;
         cfg_ff.max_delta_t <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pca_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   pca_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   pca_cos u_cos (
      .clock (clock),
      .reset (reset),
      .cin   (cos_req),
      .pre   (cos_pre),
      .cout  (cos_rsp),
      .busy  (cos_busy)
   );

   pca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .cos_req   (cos_req),
      .cos_pre   (cos_pre),
      .cos_rsp   (cos_rsp),
      .cos_busy  (cos_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/pca_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_front: input classification
// Accepts items, drops the ones that do nothing, folds pair displacements by
// the minimum image rule and hands commands to the queue.
// ----------------------------------------------------------------------------
module pca_front (
   input  logic              clock,
   input  logic              reset,
   input  pca_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  pca_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output pca_pkg::cmd_type  q_cmd
);

   // fold one axis once into the periodic box
   function automatic logic signed [pca_pkg::DISP_W-1:0] fold(
      input logic [pca_pkg::POS_W-1:0] a,
      input logic [pca_pkg::POS_W-1:0] b,
      input logic [pca_pkg::POS_W-1:0] l
   );
      logic [pca_pkg::POS_W:0]             diff;
      logic signed [pca_pkg::DISP_W-1:0]   d;
      logic signed [pca_pkg::DISP_W:0]     d2;
      logic signed [pca_pkg::DISP_W:0]     ls;
      logic signed [pca_pkg::DISP_W-1:0]   le;
      diff = {1'b0, a} - {1'b0, b};
      d    = {diff[pca_pkg::POS_W], diff};
      d2   = {d, 1'b0};
      ls   = {3'b000, l};
      le   = {2'b00, l};
      if (d2 > ls) begin
         fold = d - le;
      end else if (d2 < -ls) begin
         fold = d + le;
      end else begin
         fold = d;
      end
   endfunction

   logic             vld_ff, vld_in;
   pca_pkg::cmd_type cmd_ff, cmd_in;
   logic             accept;
   logic             lag_ok;
   logic             keep;

   assign q_push    = vld_ff && !q_full;
   assign req_ready = !vld_ff || q_push;
   assign accept    = req_valid && req_ready;
   assign q_cmd     = cmd_ff;

   // classify the incoming item
   always_comb begin
      lag_ok = (req_data.time_lag <= cfg.max_delta_t) &&
               ({1'b0, req_data.time_lag} < (pca_pkg::LAG_W+1)'(pca_pkg::TIME_BINS));
      cmd_in.lag   = req_data.time_lag;
      cmd_in.total = req_data.particle_total;
      cmd_in.dx    = fold(req_data.pos_a_x, req_data.pos_b_x, cfg.box_x);
      cmd_in.dy    = fold(req_data.pos_a_y, req_data.pos_b_y, cfg.box_y);
      cmd_in.dz    = fold(req_data.pos_a_z, req_data.pos_b_z, cfg.box_z);
      cmd_in.kind  = pca_pkg::CMD_READ;
      keep         = 1'b0;
      unique case (req_data.opcode)
         pca_pkg::OP_PAIR: begin
            cmd_in.kind = pca_pkg::CMD_PAIR;
            keep = lag_ok && (req_data.particle_id_a != req_data.particle_id_b);
         end
         pca_pkg::OP_SAMPLE: begin
            cmd_in.kind = pca_pkg::CMD_SAMPLE;
            keep = lag_ok;
         end
         pca_pkg::OP_READ: begin
            cmd_in.kind = pca_pkg::CMD_READ;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // hold one classified command
   always_comb begin
      if (accept && keep) begin
         vld_in = 1'b1;
      end else if (q_push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== src/pca_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_queue: command queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module pca_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pca_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output pca_pkg::cmd_type  head
);

   pca_pkg::cmd_type            mem_ff [pca_pkg::QDEPTH];
   logic [pca_pkg::QAW-1:0]     wr_ff, wr_in;
   logic [pca_pkg::QAW-1:0]     rd_ff, rd_in;
   logic [pca_pkg::QAW:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == (pca_pkg::QAW+1)'(pca_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/pca_cos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_cos: phase and cosine pipeline
// Seven stages: k*s, split phase product, quadrant fold, then the sine
// polynomial one multiply per stage. No stall: one entry per cycle.
// ----------------------------------------------------------------------------
module pca_cos (
   input  logic                  clock,
   input  logic                  reset,
   input  pca_pkg::cos_req_type  cin,
   output pca_pkg::cos_tag_type  pre,
   output pca_pkg::cos_rsp_type  cout,
   output logic                  busy
);

   localparam int NST = 7;
   localparam logic [16:0] PHASE_HI_C = pca_pkg::PHASE_HI;
   localparam logic [16:0] PHASE_LO_C = pca_pkg::PHASE_LO;

   logic                  vld_ff  [NST];
   logic [pca_pkg::AW-1:0] addr_ff [NST];

   logic signed [43:0] p_ff, p_in;
   logic signed [61:0] hi_ff, hi_in, lo_ff, lo_in;
   logic signed [63:0] full;
   logic [15:0]        angle;
   logic [15:0]        turn;
   logic [14:0]        z3_ff, z3_in;
   logic               n3_ff, n4_ff, n5_ff, n6_ff;
   logic [14:0]        z4_ff, z5_ff, z6_ff;
   logic [14:0]        q4_ff, q4_in, q5_ff;
   logic [14:0]        t5_ff, t5_in;
   logic [14:0]        u6_ff, u6_in;
   logic [29:0]        zz, zc, zt, zu;
   logic [14:0]        y;
   logic signed [pca_pkg::COS_W-1:0] cos_ff, cos_in;

   // stage datapath
   always_comb begin
      p_in  = $signed({1'b0, cin.k}) * cin.s;
      hi_in = p_ff * $signed({1'b0, PHASE_HI_C});
      lo_in = p_ff * $signed({1'b0, PHASE_LO_C});
      full  = (64'(hi_ff) <<< 17) + 64'(lo_ff);
      angle = full[63:48];
      turn  = angle + 16'h4000;
      z3_in = turn[14] ? 15'(15'd16384 - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
      zz    = 30'(z3_ff) * 30'(z3_ff);
      q4_in = 15'(zz >> 14);
      zc    = 30'(q4_ff) * 30'(pca_pkg::POLY_C);
      t5_in = 15'(30'(pca_pkg::POLY_B) - (zc >> 14));
      zt    = 30'(q5_ff) * 30'(t5_ff);
      u6_in = 15'(30'(pca_pkg::POLY_A) - (zt >> 14));
      zu    = 30'(z6_ff) * 30'(u6_ff);
      y     = 15'(zu >> 14);
      cos_in = n6_ff ? -$signed({1'b0, y}) : $signed({1'b0, y});
   end

   // advance payload
   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      z3_ff  <= z3_in;
      n3_ff  <= turn[15];
      z4_ff  <= z3_ff;
      n4_ff  <= n3_ff;
      q4_ff  <= q4_in;
      z5_ff  <= z4_ff;
      n5_ff  <= n4_ff;
      q5_ff  <= q4_ff;
      t5_ff  <= t5_in;
      z6_ff  <= z5_ff;
      n6_ff  <= n5_ff;
      u6_ff  <= u6_in;
      cos_ff <= cos_in;
      addr_ff[0] <= cin.addr;
      for (int i = 1; i < NST; i++) begin
         addr_ff[i] <= addr_ff[i-1];
      end
   end

   // advance valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= cin.valid;
         for (int i = 1; i < NST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i < NST; i++) begin
         busy = busy | vld_ff[i];
      end
   end

   assign pre.valid   = vld_ff[NST-2];
   assign pre.addr    = addr_ff[NST-2];
   assign cout.valid  = vld_ff[NST-1];
   assign cout.addr   = addr_ff[NST-1];
   assign cout.value  = cos_ff;

endmodule

// ===== src/pca_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_back: command execution
// Issues pair work into the cosine pipeline, accumulates into the sum
// memory, counts samples, and walks the read out through a bit-serial divider.
// ----------------------------------------------------------------------------
module pca_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pca_pkg::cfg_type      cfg,
   input  logic                  q_empty,
   input  pca_pkg::cmd_type      q_head,
   output logic                  q_pop,
   output pca_pkg::cos_req_type  cos_req,
   input  pca_pkg::cos_tag_type  cos_pre,
   input  pca_pkg::cos_rsp_type  cos_rsp,
   input  logic                  cos_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pca_pkg::rsp_type      rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b00000001,
      ST_PAIR    = 8'b00000010,
      ST_DRAIN   = 8'b00000100,
      ST_RD_ADDR = 8'b00001000,
      ST_RD_LOAD = 8'b00010000,
      ST_RD_PREP = 8'b00100000,
      ST_RD_DIV  = 8'b01000000,
      ST_RD_OUT  = 8'b10000000
   } state_type;

   localparam logic signed [pca_pkg::ACC_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [pca_pkg::ACC_W:0] SUM_MIN = -49'sh0_8000_0000_0000;

   state_type state_ff, state_in;

   logic [pca_pkg::KCW-1:0]          k_ff, k_in;
   logic [pca_pkg::LAG_W-1:0]        lag_ff, lag_in;
   logic signed [pca_pkg::SUM_W-1:0] s_ff, s_in;
   logic [pca_pkg::TOT_W-1:0]        total_ff, total_in;
   logic [pca_pkg::KCW-1:0]          kc_ff, kc_in;
   logic [pca_pkg::LW-1:0]           tc_ff, tc_in;
   logic signed [pca_pkg::SUM_W-1:0] head_s;

   // sum memory and its per-entry valid bits
   logic signed [pca_pkg::ACC_W-1:0] acc_mem [pca_pkg::ACC_DEPTH];
   logic [pca_pkg::ACC_DEPTH-1:0]    acc_vld_ff;
   logic signed [pca_pkg::ACC_W-1:0] rd_data_ff;
   logic                             rd_vld_ff;
   logic                             rd_en;
   logic [pca_pkg::AW-1:0]           rd_addr;
   logic [pca_pkg::AW-1:0]           ro_addr;
   logic                             fwd_vld_ff;
   logic [pca_pkg::AW-1:0]           fwd_addr_ff;
   logic signed [pca_pkg::ACC_W-1:0] fwd_data_ff;
   logic signed [pca_pkg::ACC_W-1:0] acc_old;
   logic signed [pca_pkg::ACC_W:0]   acc_sum;
   logic signed [pca_pkg::ACC_W-1:0] acc_new;

   // sample counts
   logic [pca_pkg::CNT_W-1:0] cnt_ff [pca_pkg::TIME_BINS];
   logic [pca_pkg::LW-1:0]    cnt_idx;
   logic [pca_pkg::CNT_W-1:0] cnt_cur;
   logic                      cnt_we;

   // divider
   logic [51:0]               den_ff, den_in;
   logic [49:0]               mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic                      zero_ff, zero_in;
   logic                      ovf_ff, ovf_in;
   logic [53:0]               rem_ff, rem_in;
   logic [31:0]               low_ff, low_in;
   logic [31:0]               quo_ff, quo_in;
   logic [4:0]                bit_ff, bit_in;
   logic signed [pca_pkg::ACC_W-1:0] ro_sum;
   logic [pca_pkg::ACC_W-1:0] ro_abs;
   logic [pca_pkg::CNT_W-1:0] cnt_one;
   logic [53:0]               numer;
   logic [54:0]               den2;
   logic [54:0]               rem2;
   logic signed [pca_pkg::CORR_W-1:0] val;
   logic                      ro_last;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   pca_pkg::rsp_type rsp_data_ff;
   logic             rsp_load;

   assign head_s = pca_pkg::SUM_W'(q_head.dx) + pca_pkg::SUM_W'(q_head.dy)
                 + pca_pkg::SUM_W'(q_head.dz);
   assign ro_addr = pca_pkg::AW'(int'(kc_ff) * pca_pkg::TIME_BINS + int'(tc_ff));
   assign ro_last = (int'(kc_ff) == pca_pkg::NUM_K - 1) &&
                    (int'(tc_ff) == pca_pkg::TIME_BINS - 1);
   assign cnt_idx = (state_ff == ST_IDLE) ? q_head.lag[pca_pkg::LW-1:0] : tc_ff;
   assign cnt_cur = cnt_ff[cnt_idx];
   assign den2    = 55'(den_ff) << 1;
   assign rem2    = {rem_ff, low_ff[31]};

   // result value with saturation
   always_comb begin
      if (zero_ff) begin
         val = '0;
      end else if (neg_ff) begin
         val = (ovf_ff || quo_ff[31]) ? 32'sh8000_0000 : -$signed(quo_ff);
      end else begin
         val = (ovf_ff || quo_ff[31]) ? 32'sh7FFF_FFFF : $signed(quo_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      lag_in   = lag_ff;
      s_in     = s_ff;
      total_in = total_ff;
      kc_in    = kc_ff;
      tc_in    = tc_ff;
      den_in   = den_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      q_pop    = 1'b0;
      cnt_we   = 1'b0;
      rsp_load = 1'b0;
      cos_req.valid = 1'b0;
      cos_req.k     = cfg.wave_number[k_ff];
      cos_req.s     = s_ff;
      cos_req.addr  = pca_pkg::AW'(int'(k_ff) * pca_pkg::TIME_BINS + int'(lag_ff));
      ro_sum  = rd_vld_ff ? rd_data_ff : '0;
      ro_abs  = ro_sum[pca_pkg::ACC_W-1] ? pca_pkg::ACC_W'(-ro_sum)
                                         : pca_pkg::ACC_W'(ro_sum);
      cnt_one = (cnt_cur == '0) ? pca_pkg::CNT_W'(1) : cnt_cur;
      numer   = (54'(mag_ff) << 1) + 54'(den_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_head.kind)
                  pca_pkg::CMD_PAIR: begin
                     // issue the first wave number at once
                     cos_req.valid = 1'b1;
                     cos_req.k     = cfg.wave_number[0];
                     cos_req.s     = head_s;
                     cos_req.addr  = pca_pkg::AW'(q_head.lag);
                     s_in   = head_s;
                     lag_in = q_head.lag;
                     k_in   = pca_pkg::KCW'(1);
                     if (pca_pkg::NUM_K > 1) begin
                        state_in = ST_PAIR;
                     end
                  end
                  pca_pkg::CMD_SAMPLE: begin
                     cnt_we = 1'b1;
                  end
                  pca_pkg::CMD_READ: begin
                     total_in = q_head.total;
                     kc_in    = '0;
                     tc_in    = '0;
                     state_in = ST_DRAIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PAIR: begin
            cos_req.valid = 1'b1;
            k_in = k_ff + 1'b1;
            if (int'(k_ff) == pca_pkg::NUM_K - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (!cos_busy) begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_LOAD;
         end
         ST_RD_LOAD: begin
            den_in   = total_ff * cnt_one;
            mag_in   = {ro_abs, 2'b00};
            neg_in   = ro_sum[pca_pkg::ACC_W-1];
            zero_in  = (total_ff == '0);
            state_in = ST_RD_PREP;
         end
         ST_RD_PREP: begin
            ovf_in   = 54'(numer[53:32]) >= 54'(den2);
            rem_in   = 54'(numer[53:32]);
            low_in   = numer[31:0];
            quo_in   = '0;
            bit_in   = '0;
            state_in = ST_RD_DIV;
         end
         ST_RD_DIV: begin
            // one quotient bit per cycle
            if (rem2 >= den2) begin
               rem_in = 54'(rem2 - den2);
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = 54'(rem2);
               quo_in = {quo_ff[30:0], 1'b0};
            end
            low_in = {low_ff[30:0], 1'b0};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 5'd31) begin
               state_in = ST_RD_OUT;
            end
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (ro_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD_ADDR;
                  if (int'(tc_ff) == pca_pkg::TIME_BINS - 1) begin
                     tc_in = '0;
                     kc_in = kc_ff + 1'b1;
                  end else begin
                     tc_in = tc_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         kc_ff    <= '0;
         tc_ff    <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         kc_ff    <= kc_in;
         tc_ff    <= tc_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      lag_ff   <= lag_in;
      s_ff     <= s_in;
      total_ff <= total_in;
      den_ff   <= den_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      ovf_ff   <= ovf_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quo_ff   <= quo_in;
   end

   // saturating sample count update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pca_pkg::TIME_BINS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we && (cnt_cur != '1)) begin
         cnt_ff[cnt_idx] <= cnt_cur + 1'b1;
      end
   end

   // accumulate with forward from the write of the previous cycle
   always_comb begin
      rd_en   = cos_pre.valid || (state_ff == ST_RD_ADDR);
      rd_addr = cos_pre.valid ? cos_pre.addr : ro_addr;
      if (fwd_vld_ff && (fwd_addr_ff == cos_rsp.addr)) begin
         acc_old = fwd_data_ff;
      end else begin
         acc_old = rd_vld_ff ? rd_data_ff : '0;
      end
      acc_sum = (pca_pkg::ACC_W+1)'(acc_old) + (pca_pkg::ACC_W+1)'(cos_rsp.value);
      if (acc_sum > SUM_MAX) begin
         acc_new = pca_pkg::ACC_W'(SUM_MAX);
      end else if (acc_sum < SUM_MIN) begin
         acc_new = pca_pkg::ACC_W'(SUM_MIN);
      end else begin
         acc_new = pca_pkg::ACC_W'(acc_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (cos_rsp.valid) begin
         acc_mem[cos_rsp.addr] <= acc_new;
      end
      if (rd_en) begin
         rd_data_ff <= acc_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (cos_rsp.valid) begin
            acc_vld_ff[cos_rsp.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= acc_vld_ff[rd_addr];
         end
         fwd_vld_ff <= cos_rsp.valid;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= cos_rsp.addr;
      fwd_data_ff <= acc_new;
   end

   // result register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.wave_index  <= 2'(kc_ff);
         rsp_data_ff.lag_index   <= 4'(tc_ff);
         rsp_data_ff.correlation <= val;
         rsp_data_ff.last        <= ro_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // read out starts only on a drained cosine pipeline
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_ADDR) |-> !cos_busy)
      else $error("read out started with pair work in flight");

   // results come only from the read out walk
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RD_OUT))
      else $error("result raised outside read out");

   // no accumulate during read out
   a_no_acc: assert property (@(posedge clock) disable iff (reset)
      cos_rsp.valid |-> !(state_ff == ST_RD_ADDR || state_ff == ST_RD_LOAD ||
                          state_ff == ST_RD_PREP || state_ff == ST_RD_DIV ||
                          state_ff == ST_RD_OUT))
      else $error("accumulate overlaps read out");

endmodule
